[sv/dns_name_label_encoder_macros.svh]
// Assertion macros used by the label encoder datapath.
`ifndef DNS_NAME_LABEL_ENCODER_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DNLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DNLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/dnle_pkg.sv]
// Shared constants and controller/datapath interface types for the label encoder.
package dnle_pkg;

  localparam int LabelMax  = 192;
  localparam int LenW      = $clog2(LabelMax + 1);
  localparam int Rows      = (LabelMax + 3) / 4;
  localparam int RowW      = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int GrpMax    = (LabelMax + 2 + 3) / 4;
  localparam int GrpW      = $clog2(GrpMax + 1);
  localparam int PosW      = GrpW + 2;

  localparam logic [7:0] ChDot = 8'h2e;
  localparam logic [7:0] ChNul = 8'h00;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic advance;
  } dnle_cmd_t;

  typedef struct packed {
    logic needs_emit;
    logic final_group;
  } dnle_status_t;

endpackage

[sv/dnle_ctrl.sv]
// Controller state machine: accepts characters and sequences the output groups.
module dnle_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  dnle_pkg::dnle_status_t status,
  output dnle_pkg::dnle_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  state_t state;

  always_comb begin
    cmd.take    = (state == ST_IDLE) && in_valid;
    cmd.rd_en   = (state == ST_READ);
    cmd.advance = (state == ST_SEND) && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && status.needs_emit) begin
            state    <= ST_READ;
            in_ready <= 1'b0;
          end
        end
        ST_READ: begin
          state     <= ST_SEND;
          out_valid <= 1'b1;
        end
        ST_SEND: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (status.final_group) begin
              state    <= ST_IDLE;
              in_ready <= 1'b1;
            end else begin
              state <= ST_READ;
            end
          end
        end
        default: begin
          state     <= ST_IDLE;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

[sv/dnle_datapath.sv]
// Datapath: label store, length counter, group counter and output byte formation.
`include "dns_name_label_encoder_macros.svh"
module dnle_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             ch,
  input  dnle_pkg::dnle_cmd_t    cmd,
  output dnle_pkg::dnle_status_t status,
  output logic [7:0]             byte0,
  output logic [7:0]             byte1,
  output logic [7:0]             byte2,
  output logic [7:0]             byte3,
  output logic [2:0]             count,
  output logic                   last
);

  logic [dnle_pkg::LenW-1:0]  len;
  logic [3:0][7:0]            mem [dnle_pkg::Rows];
  logic [3:0][7:0]            rdata;
  logic [7:0]                 carry;
  logic [dnle_pkg::LenW-1:0]  slen;
  logic                       sflush;
  logic                       sends;
  logic [dnle_pkg::PosW-1:0]  snb;
  logic [dnle_pkg::GrpW-1:0]  sgroups;
  logic [dnle_pkg::GrpW-1:0]  k;

  logic                       is_dot;
  logic                       is_nul;
  logic                       flush_now;
  logic                       collect;
  logic [dnle_pkg::PosW-1:0]  nb_now;
  logic [dnle_pkg::RowW-1:0]  wrow;
  logic [1:0]                 wlane;
  logic [dnle_pkg::RowW-1:0]  raddr;
  logic [dnle_pkg::PosW-1:0]  base;
  logic [dnle_pkg::PosW-1:0]  rem;
  logic [7:0]                 lane_store [4];
  logic [7:0]                 obyte [4];
  logic [dnle_pkg::PosW-1:0]  pos;

  assign is_dot    = (ch == dnle_pkg::ChDot);
  assign is_nul    = (ch == dnle_pkg::ChNul);
  assign flush_now = (is_dot || is_nul) && (len != '0);
  assign collect   = cmd.take && !status.needs_emit &&
                     (len < dnle_pkg::LenW'(dnle_pkg::LabelMax));
  assign nb_now    = (flush_now ? (dnle_pkg::PosW'(len) + dnle_pkg::PosW'(1)) : '0) +
                     dnle_pkg::PosW'(is_nul);

  assign status.needs_emit  = flush_now || is_nul;
  assign status.final_group = ((k + dnle_pkg::GrpW'(1)) == sgroups);

  assign wrow  = dnle_pkg::RowW'(len >> 2);
  assign wlane = len[1:0];
  // The group after the last row only carries the held-over byte and the end byte.
  assign raddr = (k >= dnle_pkg::GrpW'(dnle_pkg::Rows)) ?
                 dnle_pkg::RowW'(dnle_pkg::Rows - 1) : dnle_pkg::RowW'(k);

  always_ff @(posedge clk) begin
    if (collect) begin
      mem[wrow][wlane] <= ch;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.take) begin
      if (status.needs_emit) begin
        len <= '0;
      end else if (collect) begin
        len <= len + dnle_pkg::LenW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && status.needs_emit) begin
      slen    <= len;
      sflush  <= flush_now;
      sends   <= is_nul;
      snb     <= nb_now;
      sgroups <= dnle_pkg::GrpW'((nb_now + dnle_pkg::PosW'(3)) >> 2);
      k       <= '0;
    end else if (cmd.advance) begin
      carry <= rdata[3];
      k     <= k + dnle_pkg::GrpW'(1);
    end
  end

  // Stream position p holds the length byte at 0 and label byte p-1 after it;
  // lane 0 of a later group takes the top byte of the previous row.
  always_comb begin
    lane_store[0] = carry;
    lane_store[1] = rdata[0];
    lane_store[2] = rdata[1];
    lane_store[3] = rdata[2];
    base = {k, 2'b00};
    pos  = '0;
    for (int j = 0; j < 4; j++) begin
      pos = base + dnle_pkg::PosW'(j);
      if (sflush && (pos == '0)) begin
        obyte[j] = 8'(slen);
      end else if (sflush && (pos <= dnle_pkg::PosW'(slen))) begin
        obyte[j] = lane_store[j];
      end else begin
        obyte[j] = 8'h00;
      end
    end
  end

  assign rem   = snb - base;
  assign count = (rem >= dnle_pkg::PosW'(4)) ? 3'd4 : 3'(rem);
  assign last  = sends && status.final_group;
  assign byte0 = obyte[0];
  assign byte1 = (count >= 3'd2) ? obyte[1] : 8'h00;
  assign byte2 = (count >= 3'd3) ? obyte[2] : 8'h00;
  assign byte3 = (count == 3'd4) ? obyte[3] : 8'h00;

  `DNLE_ASSERT_NOW(a_len_bound, 1'b1, len <= dnle_pkg::LenW'(dnle_pkg::LabelMax), "label length past maximum")
  `DNLE_ASSERT_NEXT(a_emit_clears, cmd.take && status.needs_emit, len == '0, "length not cleared after emit")
  `DNLE_ASSERT_NEXT(a_collect_inc, collect, len == $past(len) + dnle_pkg::LenW'(1), "length not advanced on collect")
  `DNLE_ASSERT_NEXT(a_group_step, cmd.advance, k == $past(k) + dnle_pkg::GrpW'(1), "group counter did not step")

endmodule

[sv/dns_name_label_encoder.sv]
// Encoder flow: a collected character is taken one item per cycle while idle.
// An item that ends a label or the name hands over each group from a send state that
// follows a row read state (one label store row read, one send slot per group).
// Such an item has g groups (g = ceil(bytes / 4), at most 49).
// Synchronous reset empties the label buffer and returns the controller to idle.
module dns_name_label_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte0,
  output logic [7:0] byte1,
  output logic [7:0] byte2,
  output logic [7:0] byte3,
  output logic [2:0] count,
  output logic       last
);

  dnle_pkg::dnle_cmd_t    cmd;
  dnle_pkg::dnle_status_t status;

  dnle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dnle_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ch     (ch),
    .cmd    (cmd),
    .status (status),
    .byte0  (byte0),
    .byte1  (byte1),
    .byte2  (byte2),
    .byte3  (byte3),
    .count  (count),
    .last   (last)
  );

endmodule

[test/tb_dns_name_label_encoder.sv]
// Self-checking testbench for the DNS host-name label encoder.
`timescale 1ns / 1ps

module tb_dns_name_label_encoder;

  localparam int HoldCycles = 300;
  localparam int StallLimit = 2000;
  localparam int TailCycles = 120;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] cnt;
    logic       last;
  } wire_group_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] ch = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [2:0] count;
  logic       last;

  // Predictor state: the label collected so far.
  logic [7:0]  label_buf [dnle_pkg::LabelMax];
  int          label_len = 0;
  wire_group_t pending_groups [$];
  wire_group_t want;

  int n_fail = 0;
  int n_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  dns_name_label_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .byte0     (byte0),
    .byte1     (byte1),
    .byte2     (byte2),
    .byte3     (byte3),
    .count     (count),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Works out the wire bytes caused by one accepted character and queues them in groups of four.
  task automatic encode_char(input logic [7:0] c);
    logic [7:0] wire_bytes [dnle_pkg::LabelMax + 2];
    logic [7:0] grp [4];
    int n;
    int groups;
    int cnt;
    bit ends;
    wire_group_t g;
    n = 0;
    ends = (c == dnle_pkg::ChNul);
    if ((c == dnle_pkg::ChDot || ends) && label_len > 0) begin
      wire_bytes[n] = label_len[7:0];
      n++;
      for (int i = 0; i < label_len; i++) begin
        wire_bytes[n] = label_buf[i];
        n++;
      end
      label_len = 0;
    end else if (!ends && label_len < dnle_pkg::LabelMax) begin
      // A dot on an empty buffer lands here and is kept as a character.
      label_buf[label_len] = c;
      label_len++;
    end
    if (ends) begin
      wire_bytes[n] = dnle_pkg::ChNul;
      n++;
      label_len = 0;
    end
    groups = (n + 3) / 4;
    for (int k = 0; k < groups; k++) begin
      cnt = (n - 4 * k > 4) ? 4 : n - 4 * k;
      for (int j = 0; j < 4; j++)
        grp[j] = (j < cnt) ? wire_bytes[4 * k + j] : 8'h00;
      g.b0 = grp[0];
      g.b1 = grp[1];
      g.b2 = grp[2];
      g.b3 = grp[3];
      g.cnt = cnt[2:0];
      g.last = ends && (k == groups - 1);
      pending_groups = {pending_groups, g};
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_char(c);
    n_sent++;
  endtask

  task automatic send_name(input logic [7:0] name [$]);
    foreach (name[i]) send_char(name[i]);
  endtask

  function automatic logic [7:0] random_label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == dnle_pkg::ChDot);
    return c;
  endfunction

  task automatic send_random_label(input int len);
    for (int i = 0; i < len; i++) send_char(random_label_char());
  endtask

  task automatic send_random_name();
    int n_labels;
    n_labels = $urandom_range(1, 4);
    for (int l = 0; l < n_labels; l++) begin
      // Now and then a stray dot that finds the buffer empty.
      if ($urandom_range(9) == 0) send_char(dnle_pkg::ChDot);
      send_random_label($urandom_range(1, 6));
      if (l < n_labels - 1 || $urandom_range(7) == 0) send_char(dnle_pkg::ChDot);
    end
    send_char(dnle_pkg::ChNul);
    if ($urandom_range(11) == 0) send_char(dnle_pkg::ChNul);
  endtask

  task automatic test_directed_names();
    send_name('{8'h61, 8'h62, dnle_pkg::ChDot, 8'h63, dnle_pkg::ChNul});
    send_name('{8'h01, 8'hff, 8'h7f, 8'h80, 8'h55, 8'haa, dnle_pkg::ChNul});
    send_name('{dnle_pkg::ChNul});
    // Dots on an empty buffer become label characters.
    send_name('{dnle_pkg::ChDot, 8'h78, dnle_pkg::ChDot, dnle_pkg::ChDot, dnle_pkg::ChNul});
    send_name('{8'h7a, dnle_pkg::ChDot, dnle_pkg::ChNul});
  endtask

  task automatic test_label_overflow();
    // The characters past the limit are dropped from the emitted label.
    send_random_label(dnle_pkg::LabelMax + 2);
    send_char(dnle_pkg::ChNul);
  endtask

  task automatic test_random_names(input int n_items, input int tx_pct, input int rx_pct);
    int goal;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = n_sent + n_items;
    while (n_sent < goal) send_random_name();
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_random_label(3);
      send_char(dnle_pkg::ChDot);
    end
    send_char(dnle_pkg::ChNul);
  endtask

  // Receiver: random idling, or a long hold-off once one is requested.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      n_fail++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_groups.size() == 0) begin
        n_fail++;
        $error("output group with no expected group waiting");
      end else begin
        want = pending_groups.pop_front();
        check_field("byte0", want.b0, byte0);
        check_field("byte1", want.b1, byte1);
        check_field("byte2", want.b2, byte2);
        check_field("byte3", want.b3, byte3);
        check_field("count", want.cnt, count);
        check_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 22;
    rx_idle_pct = 45;
    test_directed_names();
    test_label_overflow();
    test_random_names(25, 22, 45);
    test_random_names(25, 45, 22);
    test_random_names(25, 0, 0);
    test_output_backpressure();
    in_valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (pending_groups.size() != 0) begin
      $error("%0d expected groups never arrived", pending_groups.size());
    end
    if (n_fail == 0 && pending_groups.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
